// ===== design/aarm_pkg.sv =====
// Shared types, widths and constants of the axis-angle rotation matrix block.
// Holds the CORDIC arc-tangent table. Depends on nothing.
package aarm_pkg;

  localparam int FRAC_BITS   = 14;
  localparam int SC_FRAC     = 30;
  localparam int RND_SHIFT   = SC_FRAC - FRAC_BITS;
  localparam int STEPS       = 20;
  localparam int ANG_UP      = 13;
  localparam int XW          = 33;   // CORDIC x and y width
  localparam int ZW          = 29;   // residual angle width, 2^-20 degree
  localparam int FIFO_DEPTH  = 4;
  localparam int PTR_W       = $clog2(FIFO_DEPTH);

  localparam logic signed [17:0] DEG_TURN    = 18'sd46080;
  localparam logic signed [17:0] DEG_QUARTER = 18'sd11520;
  localparam logic signed [17:0] DEG_HALF    = 18'sd23040;
  localparam logic signed [17:0] DEG_3QUART  = 18'sd34560;
  localparam logic signed [XW-1:0] CORDIC_GAIN = 33'sd652032874;

  // One folded item on its way from the front to the back.
  typedef struct packed {
    logic signed [14:0] z;        // folded angle, 1/128 degree, within +-90 degrees
    logic               neg_cos;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  function automatic logic signed [ZW-1:0] atan_q20(input logic [4:0] idx);
    logic signed [ZW-1:0] v;
    unique case (idx)
      5'd0:  v = 29'sd47185920;
      5'd1:  v = 29'sd27855475;
      5'd2:  v = 29'sd14718068;
      5'd3:  v = 29'sd7471121;
      5'd4:  v = 29'sd3750058;
      5'd5:  v = 29'sd1876857;
      5'd6:  v = 29'sd938658;
      5'd7:  v = 29'sd469357;
      5'd8:  v = 29'sd234682;
      5'd9:  v = 29'sd117342;
      5'd10: v = 29'sd58671;
      5'd11: v = 29'sd29335;
      5'd12: v = 29'sd14668;
      5'd13: v = 29'sd7334;
      5'd14: v = 29'sd3667;
      5'd15: v = 29'sd1833;
      5'd16: v = 29'sd917;
      5'd17: v = 29'sd458;
      5'd18: v = 29'sd229;
      5'd19: v = 29'sd115;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== design/axis_angle_rotation_matrix_top.sv =====
// Axis-angle (Rodrigues) rotation matrix: angle in 1/128 degree plus a Q1.14
// axis in, nine saturated Q1.14 matrix elements out.
// With no stalls, an input transfer passes one front register, one queue slot,
// the CORDIC load register, 20 CORDIC stages, rounding, product and output.
// Throughput: one transfer per cycle while in_stall_o is low, set by the fully pipelined CORDIC.
// Reset (rst_ni low, asynchronous) empties the pipeline and the queue.
module axis_angle_rotation_matrix_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [16:0] angle_deg_i,
  input  logic signed [15:0] axis_x_i,
  input  logic signed [15:0] axis_y_i,
  input  logic signed [15:0] axis_z_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] m00_o,
  output logic signed [15:0] m01_o,
  output logic signed [15:0] m02_o,
  output logic signed [15:0] m10_o,
  output logic signed [15:0] m11_o,
  output logic signed [15:0] m12_o,
  output logic signed [15:0] m20_o,
  output logic signed [15:0] m21_o,
  output logic signed [15:0] m22_o
);

  // The front folds the angle and hands items to a four-entry queue. The back
  // pipeline pops the queue whenever its output register can move, so a stall
  // at the output only reaches the input once the queue has filled.
  aarm_pkg::item_t      f_item, q_item;
  aarm_pkg::fifo_stat_t q_stat;
  logic                 push, pop;
  logic signed [15:0]   m [0:8];

  aarm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .angle_deg_i (angle_deg_i),
    .axis_x_i    (axis_x_i),
    .axis_y_i    (axis_y_i),
    .axis_z_i    (axis_z_i),
    .fifo_stat_i (q_stat),
    .push_o      (push),
    .item_o      (f_item)
  );

  aarm_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (f_item),
    .pop_i  (pop),
    .item_o (q_item),
    .stat_o (q_stat)
  );

  aarm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fifo_stat_i (q_stat),
    .item_i      (q_item),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .m_o         (m)
  );

  // Elements leave row by row.
  assign m00_o = m[0];
  assign m01_o = m[1];
  assign m02_o = m[2];
  assign m10_o = m[3];
  assign m11_o = m[4];
  assign m12_o = m[5];
  assign m20_o = m[6];
  assign m21_o = m[7];
  assign m22_o = m[8];

endmodule

// ===== design/aarm_front.sv =====
// Front end: accepts input transfers, wraps the angle to one turn and folds it
// into +-90 degrees. Depends on aarm_pkg.
module aarm_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic signed [16:0]    angle_deg_i,
  input  logic signed [15:0]    axis_x_i,
  input  logic signed [15:0]    axis_y_i,
  input  logic signed [15:0]    axis_z_i,
  input  aarm_pkg::fifo_stat_t  fifo_stat_i,
  output logic                  push_o,
  output aarm_pkg::item_t       item_o
);

  logic             valid_q;
  aarm_pkg::item_t  item_q, item_d;
  logic signed [17:0] ang, r, r1;

  assign in_stall_o = valid_q && fifo_stat_i.full;
  assign push_o     = valid_q && !fifo_stat_i.full;
  assign item_o     = item_q;

  always_comb begin
    ang = 18'(angle_deg_i);
    if (ang < 0) begin
      r1 = ang + aarm_pkg::DEG_TURN;
      r  = (r1 < 0) ? r1 + aarm_pkg::DEG_TURN : r1;
    end else begin
      r1 = ang - aarm_pkg::DEG_TURN;
      r  = (ang >= aarm_pkg::DEG_TURN) ? r1 : ang;
    end
    item_d.ax = axis_x_i;
    item_d.ay = axis_y_i;
    item_d.az = axis_z_i;
    item_d.neg_cos = 1'b0;
    if (r <= aarm_pkg::DEG_QUARTER) begin
      item_d.z = 15'(r);
    end else if (r < aarm_pkg::DEG_3QUART) begin
      item_d.z = 15'(aarm_pkg::DEG_HALF - r);
      item_d.neg_cos = 1'b1;
    end else begin
      item_d.z = 15'(r - aarm_pkg::DEG_TURN);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      item_q <= item_d;
    end
  end

endmodule

// ===== design/aarm_fifo.sv =====
// Short queue of folded items between the front and the back.
// Depends on aarm_pkg.
module aarm_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  aarm_pkg::item_t       item_i,
  input  logic                  pop_i,
  output aarm_pkg::item_t       item_o,
  output aarm_pkg::fifo_stat_t  stat_o
);

  aarm_pkg::item_t mem_q [0:aarm_pkg::FIFO_DEPTH-1];
  logic [aarm_pkg::PTR_W-1:0] wr_q, rd_q;
  logic [aarm_pkg::PTR_W:0]   cnt_q;

  assign stat_o.full  = (cnt_q == (aarm_pkg::PTR_W+1)'(aarm_pkg::FIFO_DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign item_o       = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !stat_o.full) else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !stat_o.empty) else $error("pop from empty queue");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (aarm_pkg::PTR_W+1)'(aarm_pkg::FIFO_DEPTH)) else $error("queue count overflow");
  a_cnt_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (cnt_q == $past(cnt_q) + 1'b1)) else $error("count not tracking");

endmodule

// ===== design/aarm_back.sv =====
// Back end: 20-stage pipelined CORDIC, product stages and saturating output
// register. Depends on aarm_pkg.
module aarm_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  aarm_pkg::fifo_stat_t  fifo_stat_i,
  input  aarm_pkg::item_t       item_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic signed [15:0]    m_o [0:8]
);

  localparam int S = aarm_pkg::STEPS;

  logic en;
  logic [S:0] v_q;
  logic vr_q, vp_q, vo_q;

  logic signed [aarm_pkg::XW-1:0] x_q [0:S];
  logic signed [aarm_pkg::XW-1:0] y_q [0:S];
  logic signed [aarm_pkg::ZW-1:0] z_q [0:S];
  logic                           neg_q [0:S];
  logic signed [15:0]             a_q [0:S][0:2];

  logic signed [17:0] c_q, s_q, cp_q;
  logic signed [31:0] aa_q [0:8];
  logic signed [16:0] cr_q [0:8];
  logic signed [23:0] e_q [0:8];
  logic signed [20:0] k_q [0:8];
  logic signed [15:0] m_q [0:8];

  logic signed [aarm_pkg::XW:0] xn;
  logic signed [aarm_pkg::XW:0] xr, yr;
  logic signed [18:0] omc;
  logic signed [50:0] prod [0:8];
  logic signed [34:0] crs  [0:8];
  logic signed [24:0] sum  [0:8];
  logic signed [16:0] cr_d [0:8];

  assign en          = !vo_q || !out_stall_i;
  assign pop_o       = en && !fifo_stat_i.empty;
  assign out_valid_o = vo_q;
  assign m_o         = m_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q  <= '0;
      vr_q <= 1'b0;
      vp_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (en) begin
      v_q  <= {v_q[S-1:0], !fifo_stat_i.empty};
      vr_q <= v_q[S];
      vp_q <= vr_q;
      vo_q <= vp_q;
    end
  end

  // Cross-product matrix entries, row by row.
  always_comb begin
    for (int k = 0; k < 9; k++) cr_d[k] = '0;
    cr_d[1] = -17'(a_q[S][2]);
    cr_d[2] =  17'(a_q[S][1]);
    cr_d[3] =  17'(a_q[S][2]);
    cr_d[5] = -17'(a_q[S][0]);
    cr_d[6] = -17'(a_q[S][1]);
    cr_d[7] =  17'(a_q[S][0]);
  end

  always_comb begin
    xn  = neg_q[S] ? -(aarm_pkg::XW+1)'(x_q[S]) : (aarm_pkg::XW+1)'(x_q[S]);
    xr  = (xn + ((aarm_pkg::XW+1)'(1) <<< (aarm_pkg::RND_SHIFT-1))) >>> aarm_pkg::RND_SHIFT;
    yr  = ((aarm_pkg::XW+1)'(y_q[S]) + ((aarm_pkg::XW+1)'(1) <<< (aarm_pkg::RND_SHIFT-1)))
          >>> aarm_pkg::RND_SHIFT;
    omc = (19'sd1 <<< aarm_pkg::FRAC_BITS) - 19'(c_q);
    for (int k = 0; k < 9; k++) begin
      prod[k] = 51'(omc) * 51'(aa_q[k]);
      crs[k]  = 35'(s_q) * 35'(cr_q[k]);
      sum[k]  = 25'(e_q[k]) + 25'(k_q[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x_q[0]   <= aarm_pkg::CORDIC_GAIN;
      y_q[0]   <= '0;
      z_q[0]   <= {{(aarm_pkg::ZW-15-aarm_pkg::ANG_UP){item_i.z[14]}}, item_i.z,
                   {aarm_pkg::ANG_UP{1'b0}}};
      neg_q[0] <= item_i.neg_cos;
      a_q[0][0] <= item_i.ax;
      a_q[0][1] <= item_i.ay;
      a_q[0][2] <= item_i.az;
      for (int i = 0; i < S; i++) begin
        if (!z_q[i][aarm_pkg::ZW-1]) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - aarm_pkg::atan_q20(5'(i));
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + aarm_pkg::atan_q20(5'(i));
        end
        neg_q[i+1] <= neg_q[i];
        a_q[i+1]   <= a_q[i];
      end
      // Rounding stage: sine, cosine and the axis outer product.
      c_q <= 18'(xr);
      s_q <= 18'(yr);
      for (int r = 0; r < 3; r++) begin
        for (int cc = 0; cc < 3; cc++) begin
          aa_q[r*3+cc] <= 32'(a_q[S][r]) * 32'(a_q[S][cc]);
        end
      end
      cr_q <= cr_d;
      // Product stage.
      cp_q <= c_q;
      for (int k = 0; k < 9; k++) begin
        e_q[k] <= 24'((prod[k] + (51'sd1 <<< (2*aarm_pkg::FRAC_BITS-1)))
                      >>> (2*aarm_pkg::FRAC_BITS))
                  + ((k % 4 == 0) ? 24'(c_q) : 24'sd0);
        k_q[k] <= 21'((crs[k] + (35'sd1 <<< (aarm_pkg::FRAC_BITS-1))) >>> aarm_pkg::FRAC_BITS);
      end
      // Output stage: sum and saturate.
      for (int k = 0; k < 9; k++) begin
        if (sum[k] > 25'sd32767)       m_q[k] <= 16'sh7fff;
        else if (sum[k] < -25'sd32768) m_q[k] <= 16'sh8000;
        else                           m_q[k] <= 16'(sum[k]);
      end
    end
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vo_q && out_stall_i) |=> (vo_q && $stable(m_q[0]) && $stable(cp_q)))
    else $error("result changed under stall");
  a_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && vp_q) |=> vo_q) else $error("result lost at output stage");
  a_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> v_q[0]) else $error("popped item did not enter pipeline");

endmodule
